/* sv/ssm_pkg.sv */
// Shared types and request codes of the sorted sequence merger.
package ssm_pkg;

    localparam int VAL_W = 32;

    // Request codes carried on req_type
    localparam logic [1:0] REQ_LOAD_A = 2'd0;
    localparam logic [1:0] REQ_LOAD_B = 2'd1;
    localparam logic [1:0] REQ_MERGE  = 2'd2;

    // One merged result as it leaves the sequencer
    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic                    last;
        logic                    empty;
        logic                    ovf;
    } result_t;

endpackage

/* sv/ssm_ram.sv */
// Single-port-write, single-port-read memory with a registered read.
module ssm_ram #(
    parameter int WORDS = 32,
    parameter int AW    = 5,
    parameter int W     = 32
) (
    input  logic         clk,
    input  logic         wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [W-1:0] wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [W-1:0] rd_data
);

    logic [W-1:0] mem [WORDS];
    logic [W-1:0] rd_data_reg;

    // Write the addressed word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read of the addressed word
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/ssm_ctrl.sv */
// Load and merge sequencer: counts, read pointers and the two-pointer merge step.
module ssm_ctrl
    import ssm_pkg::*;
#(
    parameter int DEPTH = 32,
    parameter int CW    = $clog2(DEPTH + 1),
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic signed [VAL_W-1:0] element_value,
    input  logic                    slot_free,
    output logic                    emit,
    output result_t                 res,
    output logic                    wr_en_a,
    output logic                    wr_en_b,
    output logic [AW-1:0]           wr_addr_a,
    output logic [AW-1:0]           wr_addr_b,
    output logic [VAL_W-1:0]        wr_data,
    output logic [AW-1:0]           rd_addr_a,
    output logic [AW-1:0]           rd_addr_b,
    input  logic signed [VAL_W-1:0] rd_data_a,
    input  logic signed [VAL_W-1:0] rd_data_b
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic [CW-1:0] idx_a_reg, idx_a_next;
    logic [CW-1:0] idx_b_reg, idx_b_next;
    logic          drop_reg, drop_next;

    logic          accept;
    logic          take_a;
    logic          finish;
    logic [CW:0]   total;
    logic [CW:0]   pos;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign wr_data   = element_value;
    assign wr_addr_a = cnt_a_reg[AW-1:0];
    assign wr_addr_b = cnt_b_reg[AW-1:0];

    // Address the heads the next cycle will compare
    assign rd_addr_a = idx_a_next[AW-1:0];
    assign rd_addr_b = idx_b_next[AW-1:0];

    assign total  = {1'b0, cnt_a_reg} + {1'b0, cnt_b_reg};
    assign pos    = {1'b0, idx_a_reg} + {1'b0, idx_b_reg} + {{CW{1'b0}}, 1'b1};
    assign take_a = (idx_a_reg < cnt_a_reg)
                    && ((idx_b_reg >= cnt_b_reg) || (rd_data_a <= rd_data_b));

    // Next state: append on load, one merge step per free output slot
    always_comb
    begin
        state_next = state_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        idx_a_next = idx_a_reg;
        idx_b_next = idx_b_reg;
        drop_next  = drop_reg;
        wr_en_a    = 1'b0;
        wr_en_b    = 1'b0;
        emit       = 1'b0;
        finish     = 1'b0;
        res.value  = rd_data_a;
        res.last   = 1'b0;
        res.empty  = 1'b0;
        res.ovf    = drop_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (req_type)
                        REQ_LOAD_A:
                        begin
                            if (cnt_a_reg < CW'(DEPTH))
                            begin
                                wr_en_a    = 1'b1;
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        REQ_LOAD_B:
                        begin
                            if (cnt_b_reg < CW'(DEPTH))
                            begin
                                wr_en_b    = 1'b1;
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end
                            else
                            begin
                                drop_next = 1'b1;
                            end
                        end
                        REQ_MERGE:
                        begin
                            state_next = ST_RUN;
                        end
                        default:
                        begin
                            // unused code: no effect
                        end
                    endcase
                end
            end
            ST_RUN:
            begin
                if (slot_free)
                begin
                    emit = 1'b1;
                    if (total == '0)
                    begin
                        // both stores empty: single marker result
                        res.value = '0;
                        res.last  = 1'b1;
                        res.empty = 1'b1;
                        finish    = 1'b1;
                    end
                    else
                    begin
                        res.last = (pos == total);
                        finish   = (pos == total);
                        if (take_a)
                        begin
                            res.value  = rd_data_a;
                            idx_a_next = idx_a_reg + 1'b1;
                        end
                        else
                        begin
                            res.value  = rd_data_b;
                            idx_b_next = idx_b_reg + 1'b1;
                        end
                    end
                end
                // clear counts, pointers and the overflow flag after the final result
                if (finish)
                begin
                    state_next = ST_IDLE;
                    cnt_a_next = '0;
                    cnt_b_next = '0;
                    idx_a_next = '0;
                    idx_b_next = '0;
                    drop_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            idx_a_reg <= '0;
            idx_b_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            idx_a_reg <= idx_a_next;
            idx_b_reg <= idx_b_next;
            drop_reg  <= drop_next;
        end
    end

endmodule

/* sv/sorted_sequence_merger_unit.sv */
// Top level of the two-way merger of sorted sequences.
//
//   channel | direction | transfer when          | payload
//   in      | input     | in_valid & in_ready    | req_type, element_value
//   out     | output    | out_valid & out_ready  | merged_value, last_of_run,
//           |           |                        | is_empty, overflow_seen
//
// A load is taken even while a result waits at the output.
// A merge gives one result per element (count A plus count B), or one for an
// empty merge; the rate is set by the single read port of each store, whose
// registered head is compared once per cycle while the output slot is free.
// Input is refused for the whole merge. Output stalls hold the merge step.
// Reset clears counts, pointers and the overflow flag; the stores are not cleared.
module sorted_sequence_merger_unit
    import ssm_pkg::*;
#(
    parameter int DEPTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [1:0]              req_type,
    input  logic signed [VAL_W-1:0] element_value,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VAL_W-1:0] merged_value,
    output logic                    last_of_run,
    output logic                    is_empty,
    output logic                    overflow_seen
);

    localparam int CW    = $clog2(DEPTH + 1);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WORDS = 1 << AW;

    logic             slot_free;
    logic             emit;
    result_t          res;
    result_t          out_reg;
    logic             out_valid_reg;
    logic             wr_en_a, wr_en_b;
    logic [AW-1:0]    wr_addr_a, wr_addr_b;
    logic [VAL_W-1:0] wr_data;
    logic [AW-1:0]    rd_addr_a, rd_addr_b;
    logic [VAL_W-1:0] rd_data_a, rd_data_b;

    ssm_ram #(
        .WORDS (WORDS),
        .AW    (AW),
        .W     (VAL_W)
    ) u_store_a (
        .clk     (clk),
        .wr_en   (wr_en_a),
        .wr_addr (wr_addr_a),
        .wr_data (wr_data),
        .rd_addr (rd_addr_a),
        .rd_data (rd_data_a)
    );

    ssm_ram #(
        .WORDS (WORDS),
        .AW    (AW),
        .W     (VAL_W)
    ) u_store_b (
        .clk     (clk),
        .wr_en   (wr_en_b),
        .wr_addr (wr_addr_b),
        .wr_data (wr_data),
        .rd_addr (rd_addr_b),
        .rd_data (rd_data_b)
    );

    ssm_ctrl #(
        .DEPTH (DEPTH),
        .CW    (CW),
        .AW    (AW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .req_type      (req_type),
        .element_value (element_value),
        .slot_free     (slot_free),
        .emit          (emit),
        .res           (res),
        .wr_en_a       (wr_en_a),
        .wr_en_b       (wr_en_b),
        .wr_addr_a     (wr_addr_a),
        .wr_addr_b     (wr_addr_b),
        .wr_data       (wr_data),
        .rd_addr_a     (rd_addr_a),
        .rd_addr_b     (rd_addr_b),
        .rd_data_a     ($signed(rd_data_a)),
        .rd_data_b     ($signed(rd_data_b))
    );

    // Output slot is free when empty or being drained this cycle
    assign slot_free = !out_valid_reg || out_ready;

    // Track output occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Capture the result payload
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= res;
        end
    end

    assign out_valid     = out_valid_reg;
    assign merged_value  = out_reg.value;
    assign last_of_run   = out_reg.last;
    assign is_empty      = out_reg.empty;
    assign overflow_seen = out_reg.ovf;

endmodule

/* sv/ssm_checker.sv */
// Port-level checks of the merger, bound to the top level.
module ssm_checker
    import ssm_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [VAL_W-1:0] merged_value,
    input logic                    last_of_run,
    input logic                    is_empty,
    input logic                    overflow_seen
);

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(merged_value)
            && $stable(last_of_run) && $stable(is_empty) && $stable(overflow_seen))
        else $error("stalled result changed");

    // An empty marker is always the final result
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && is_empty |-> last_of_run)
        else $error("empty result not marked last");

    // Input is refused while a merge still has results to give
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> !in_ready)
        else $error("input taken during merge");

    // Results of one merge follow back to back with the same overflow flag
    a_ovf_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_of_run |=>
            out_valid && (overflow_seen == $past(overflow_seen)))
        else $error("merge run broken or overflow flag changed");

endmodule

bind sorted_sequence_merger_unit ssm_checker u_ssm_checker (.*);
